@@ sv/hrdp_pkg.sv @@
// Shared types and constants of the HID report descriptor parser.
`default_nettype none

package hrdp_pkg;

   // Item tags, with the data size code bits masked off.
   localparam logic [7:0] TAG_USAGE_PAGE = 8'h04;
   localparam logic [7:0] TAG_USAGE      = 8'h08;
   localparam logic [7:0] TAG_LOG_MIN    = 8'h14;
   localparam logic [7:0] TAG_LOG_MAX    = 8'h24;
   localparam logic [7:0] TAG_REP_SIZE   = 8'h74;
   localparam logic [7:0] TAG_REP_ID     = 8'h84;
   localparam logic [7:0] TAG_REP_COUNT  = 8'h94;
   localparam logic [7:0] TAG_INPUT      = 8'h80;
   localparam logic [7:0] TAG_OUTPUT     = 8'h90;
   localparam logic [7:0] TAG_FEATURE    = 8'hB0;
   localparam logic [7:0] TAG_COLLECTION = 8'hA0;
   localparam logic [7:0] TAG_END_COLL   = 8'hC0;
   localparam logic [7:0] TAG_MASK       = 8'hFC;

   // Size code that carries four data bytes.
   localparam logic [1:0] SIZE_FOUR = 2'd3;

   // Page that marks a collection index node.
   localparam logic [15:0] INDEX_PAGE = 16'h00FF;

   // Main item kinds.
   localparam logic [1:0] KIND_INPUT   = 2'd0;
   localparam logic [1:0] KIND_OUTPUT  = 2'd1;
   localparam logic [1:0] KIND_FEATURE = 2'd2;

   // Error codes of a result.
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_CLAMP = 2'd2;
   localparam logic [1:0] ERR_STACK = 2'd3;

   // Request op codes.
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] desc_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  attribute;
      logic [7:0]  report_number;
      logic [15:0] bit_offset;
      logic [7:0]  bit_size;
      logic [31:0] logical_low;
      logic [31:0] logical_high;
      logic [15:0] usage_page;
      logic [15:0] usage_id;
      logic [4:0]  path_depth;
      logic        last;
      logic [1:0]  error;
   } rsp_type;

   // A completed item from the byte assembler.
   typedef struct packed {
      logic        done;
      logic [7:0]  prefix;
      logic [31:0] data;
   } item_type;

endpackage

`default_nettype wire

@@ sv/hrdp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hrdp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                            wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ sv/hrdp_item_asm.sv @@
// Gathers descriptor bytes into items: prefix plus little-endian data.
`default_nettype none

module hrdp_item_asm
   import hrdp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       restart,
   input  wire logic       take,
   input  wire logic [7:0] byte_in,
   output item_type        item
);

   logic [7:0]  prefix_ff, prefix_in;
   logic [31:0] accum_ff, accum_in;
   logic [2:0]  left_ff, left_in;
   logic [2:0]  len_new, len_cur;
   logic [1:0]  pos;
   logic [31:0] shifted;

   // Data byte count of a size code.
   function automatic logic [2:0] size_len(input logic [1:0] code);
      logic [2:0] len;
      case (code)
         2'd0:    len = 3'd0;
         2'd1:    len = 3'd1;
         2'd2:    len = 3'd2;
         default: len = 3'd4;
      endcase
      return len;
   endfunction

   // Next state and the item completed by this byte.
   always_comb begin
      len_new   = size_len(byte_in[1:0]);
      len_cur   = size_len(prefix_ff[1:0]);
      pos       = 2'(len_cur - left_ff);
      case (pos)
         2'd0:    shifted = {24'd0, byte_in};
         2'd1:    shifted = {16'd0, byte_in, 8'd0};
         2'd2:    shifted = {8'd0, byte_in, 16'd0};
         default: shifted = {byte_in, 24'd0};
      endcase
      prefix_in = prefix_ff;
      accum_in  = accum_ff;
      left_in   = left_ff;
      if (left_ff == 3'd0) begin
         item.prefix = byte_in;
         item.data   = 32'd0;
         item.done   = (len_new == 3'd0);
         if (take) begin
            prefix_in = byte_in;
            accum_in  = 32'd0;
            left_in   = len_new;
         end
      end else begin
         item.prefix = prefix_ff;
         item.data   = accum_ff | shifted;
         item.done   = (left_ff == 3'd1);
         if (take) begin
            accum_in = accum_ff | shifted;
            left_in  = left_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         prefix_ff <= 8'd0;
         accum_ff  <= 32'd0;
         left_ff   <= 3'd0;
      end else begin
         prefix_ff <= prefix_in;
         accum_ff  <= accum_in;
         left_ff   <= left_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/hid_report_descriptor_parser_core.sv @@
// Top level of the HID report descriptor parser: item execution and object emission.
//
//   Channel  Direction  Payload    Transfer when
//   req      in         req_type   req_valid && !req_stall
//   rsp      out        rsp_type   rsp_valid && !rsp_stall
//
// A byte that does not complete an item is taken in ST_IDLE. A completed item runs
// ST_EXEC, plus ST_PATH_CHK for an end collection or ST_COLL2 for an index collection.
// A main item passes ST_SEARCH and ST_SCMP per slot compared in the offset slot RAM
// (one read port), allocates or fails in ST_SEARCH, then emits its records in ST_EMIT.
// Reset, and a restart transfer, clear the stacks, counters and global items at once; no clearing pass is needed.
// A stall on rsp holds the record run; req stays stalled until the item is finished.
`default_nettype none

module hid_report_descriptor_parser_core
   import hrdp_pkg::*;
#(
   parameter int USAGE_DEPTH  = 8,
   parameter int PATH_DEPTH   = 16,
   parameter int REPORT_SLOTS = 8,
   parameter int MAX_RUN      = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data
);

   localparam int UCW = $clog2(USAGE_DEPTH + 1);
   localparam int UAW = $clog2(USAGE_DEPTH);
   localparam int PCW = $clog2(PATH_DEPTH + 1);
   localparam int PAW = $clog2(PATH_DEPTH);
   localparam int SCW = $clog2(REPORT_SLOTS + 1);
   localparam int SAW = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;
   localparam int RCW = $clog2(MAX_RUN + 1);
   localparam int SLOT_W = 26;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_COLL2, ST_PATH_CHK, ST_SEARCH, ST_SCMP, ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   item_type    item_ff, item_in;
   item_type    asm_item;
   logic [15:0] page_ff, page_in;
   logic [31:0] ustack_ff [USAGE_DEPTH];
   logic [31:0] ustack_in [USAGE_DEPTH];
   logic [31:0] upop [USAGE_DEPTH];
   logic [UCW-1:0] ucount_ff, ucount_in, ucount_pop;
   logic [PCW-1:0] pcount_ff, pcount_in;
   logic [7:0]  rid_ff, rid_in;
   logic [7:0]  size_ff, size_in;
   logic [7:0]  count_ff, count_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] high_ff, high_in;
   logic        fault_ff, fault_in;
   logic [SCW-1:0] fill_ff, fill_in;
   logic [SCW-1:0] sidx_ff, sidx_in;
   logic [SAW-1:0] slot_ff, slot_in;
   logic        found_ff, found_in;
   logic [15:0] off_ff, off_in;
   logic [1:0]  kind_ff, kind_in;
   logic [RCW-1:0] n_ff, n_in;
   logic [RCW-1:0] k_ff, k_in;
   logic        clamp_ff, clamp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        take, byte_take, restart, out_free, run_end;
   logic [7:0]  tag;
   logic [15:0] upage;
   logic [16:0] off_sum;
   logic [15:0] off_next;
   logic [1:0]  err;

   logic              path_we;
   logic [PAW-1:0]    path_waddr;
   logic [31:0]       path_wdata;
   logic [PAW-1:0]    path_raddr;
   logic [31:0]       path_rdata;
   logic              slot_we;
   logic [SAW-1:0]    slot_waddr;
   logic [SLOT_W-1:0] slot_wdata;
   logic [SAW-1:0]    slot_raddr;
   logic [SLOT_W-1:0] slot_rdata;

   hrdp_item_asm u_asm (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .take    (byte_take),
      .byte_in (req_data.desc_byte),
      .item    (asm_item)
   );

   // Collection path stack.
   hrdp_ram #(.WIDTH(32), .DEPTH(PATH_DEPTH)) u_path_ram (
      .clock (clock),
      .we    (path_we),
      .waddr (path_waddr),
      .wdata (path_wdata),
      .raddr (path_raddr),
      .rdata (path_rdata)
   );

   // Offset slots: report id, kind and running bit offset.
   hrdp_ram #(.WIDTH(SLOT_W), .DEPTH(REPORT_SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   // Usage stack after a pop: entries shift down, zero enters from beyond the stack.
   for (genvar i = 0; i < USAGE_DEPTH; i++) begin : g_pop
      if (i + 1 < USAGE_DEPTH) begin : g_mid
         assign upop[i] = (UCW'(i) < ucount_ff) ? ustack_ff[i + 1] : ustack_ff[i];
      end else begin : g_top
         assign upop[i] = (UCW'(i) < ucount_ff) ? 32'd0 : ustack_ff[i];
      end
   end
   assign ucount_pop = (ucount_ff == '0) ? '0 : ucount_ff - 1'b1;

   // Handshake and shared terms.
   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && (state_ff == ST_IDLE);
   assign restart   = take && (req_data.op == OP_RESTART);
   assign byte_take = take && (req_data.op == OP_BYTE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign run_end   = ((k_ff + 1'b1) == n_ff);
   assign tag       = item_ff.prefix & TAG_MASK;
   assign upage     = (item_ff.prefix[1:0] == SIZE_FOUR) ? item_ff.data[31:16] : page_ff;
   assign off_sum   = {1'b0, off_ff} + {9'd0, size_ff};
   assign off_next  = off_sum[16] ? 16'hFFFF : off_sum[15:0];
   assign path_raddr = PAW'(pcount_ff - 1'b1);
   assign slot_raddr = sidx_ff[SAW-1:0];

   always_comb begin
      if (fault_ff) begin
         err = ERR_STACK;
      end else if (!found_ff) begin
         err = ERR_FULL;
      end else if (clamp_ff) begin
         err = ERR_CLAMP;
      end else begin
         err = ERR_OK;
      end
   end

   // Sequencer: next values of all registers and the memory write ports.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      page_in      = page_ff;
      ustack_in    = ustack_ff;
      ucount_in    = ucount_ff;
      pcount_in    = pcount_ff;
      rid_in       = rid_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      fault_in     = fault_ff;
      fill_in      = fill_ff;
      sidx_in      = sidx_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      off_in       = off_ff;
      kind_in      = kind_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      clamp_in     = clamp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      path_we      = 1'b0;
      path_waddr   = pcount_ff[PAW-1:0];
      path_wdata   = ustack_ff[0];
      slot_we      = 1'b0;
      slot_waddr   = slot_ff;
      slot_wdata   = {rid_ff, kind_ff, off_next};

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (byte_take && asm_item.done) begin
               item_in  = asm_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (tag) inside
               TAG_USAGE_PAGE: begin
                  page_in = item_ff.data[15:0];
                  if (ucount_ff < UCW'(USAGE_DEPTH)) begin
                     ustack_in[ucount_ff[UAW-1:0]] = {item_ff.data[15:0], 16'h00FF};
                  end
               end
               TAG_USAGE: begin
                  if (ucount_ff < UCW'(USAGE_DEPTH)) begin
                     ustack_in[ucount_ff[UAW-1:0]] = {upage, item_ff.data[15:0]};
                     ucount_in = ucount_ff + 1'b1;
                  end else begin
                     fault_in = 1'b1;
                  end
               end
               TAG_COLLECTION: begin
                  ustack_in = upop;
                  ucount_in = ucount_pop;
                  if (pcount_ff < PCW'(PATH_DEPTH)) begin
                     path_we   = 1'b1;
                     pcount_in = pcount_ff + 1'b1;
                  end else begin
                     fault_in = 1'b1;
                  end
                  if (|item_ff.data[31:7]) begin
                     state_in = ST_COLL2;
                  end
               end
               TAG_END_COLL: begin
                  if (pcount_ff == '0) begin
                     fault_in = 1'b1;
                  end else begin
                     pcount_in = pcount_ff - 1'b1;
                     state_in  = ST_PATH_CHK;
                  end
               end
               TAG_INPUT, TAG_OUTPUT, TAG_FEATURE: begin
                  if (tag == TAG_INPUT) begin
                     kind_in = KIND_INPUT;
                  end else if (tag == TAG_OUTPUT) begin
                     kind_in = KIND_OUTPUT;
                  end else begin
                     kind_in = KIND_FEATURE;
                  end
                  if (count_ff != 8'd0) begin
                     clamp_in = (count_ff > 8'(MAX_RUN));
                     n_in     = clamp_in ? RCW'(MAX_RUN) : RCW'(count_ff);
                     k_in     = '0;
                     sidx_in  = '0;
                     state_in = ST_SEARCH;
                  end
               end
               TAG_REP_ID:    rid_in   = item_ff.data[7:0];
               TAG_REP_SIZE:  size_in  = item_ff.data[7:0];
               TAG_REP_COUNT: count_in = item_ff.data[7:0];
               TAG_LOG_MIN:   low_in   = item_ff.data;
               TAG_LOG_MAX:   high_in  = item_ff.data;
               default: ;
            endcase
         end
         ST_COLL2: begin
            // Index node for a collection whose data has a bit set above bit 6.
            path_wdata = {INDEX_PAGE, 9'd0, item_ff.data[6:0]};
            if (pcount_ff < PCW'(PATH_DEPTH)) begin
               path_we   = 1'b1;
               pcount_in = pcount_ff + 1'b1;
            end else begin
               fault_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_PATH_CHK: begin
            // The popped node was an index node: pop its collection too.
            if (path_rdata[31:16] == INDEX_PAGE) begin
               if (pcount_ff == '0) begin
                  fault_in = 1'b1;
               end else begin
                  pcount_in = pcount_ff - 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            if (sidx_ff == fill_ff) begin
               off_in   = 16'd0;
               state_in = ST_EMIT;
               if (fill_ff < SCW'(REPORT_SLOTS)) begin
                  slot_we    = 1'b1;
                  slot_waddr = fill_ff[SAW-1:0];
                  slot_wdata = {rid_ff, kind_ff, 16'd0};
                  slot_in    = fill_ff[SAW-1:0];
                  fill_in    = fill_ff + 1'b1;
                  found_in   = 1'b1;
               end else begin
                  found_in = 1'b0;
               end
            end else begin
               state_in = ST_SCMP;
            end
         end
         ST_SCMP: begin
            if (slot_rdata[25:16] == {rid_ff, kind_ff}) begin
               slot_in  = sidx_ff[SAW-1:0];
               off_in   = slot_rdata[15:0];
               found_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               sidx_in  = sidx_ff + 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = kind_ff;
               rsp_in.attribute      = item_ff.data[7:0];
               rsp_in.report_number  = rid_ff;
               rsp_in.bit_offset     = off_ff;
               rsp_in.bit_size       = size_ff;
               rsp_in.logical_low    = low_ff;
               rsp_in.logical_high   = high_ff;
               rsp_in.usage_page     = ustack_ff[0][31:16];
               rsp_in.usage_id       = ustack_ff[0][15:0];
               rsp_in.path_depth     = 5'(pcount_ff);
               rsp_in.last           = run_end;
               rsp_in.error          = err;
               ustack_in = upop;
               ucount_in = ucount_pop;
               if (found_ff) begin
                  off_in  = off_next;
                  slot_we = 1'b1;
               end
               k_in = k_ff + 1'b1;
               if (run_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // A restart transfer returns the stacks, counters and global items to their reset values.
      if (restart) begin
         page_in   = 16'd0;
         for (int i = 0; i < USAGE_DEPTH; i++) begin
            ustack_in[i] = 32'd0;
         end
         ucount_in = '0;
         pcount_in = '0;
         rid_in    = 8'd1;
         size_in   = 8'd0;
         count_in  = 8'd0;
         low_in    = 32'd0;
         high_in   = 32'd0;
         fault_in  = 1'b0;
         fill_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         page_ff      <= 16'd0;
         for (int i = 0; i < USAGE_DEPTH; i++) begin
            ustack_ff[i] <= 32'd0;
         end
         ucount_ff    <= '0;
         pcount_ff    <= '0;
         rid_ff       <= 8'd1;
         size_ff      <= 8'd0;
         count_ff     <= 8'd0;
         low_ff       <= 32'd0;
         high_ff      <= 32'd0;
         fault_ff     <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         page_ff      <= page_in;
         ustack_ff    <= ustack_in;
         ucount_ff    <= ucount_in;
         pcount_ff    <= pcount_in;
         rid_ff       <= rid_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         fault_ff     <= fault_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff  <= item_in;
      sidx_ff  <= sidx_in;
      slot_ff  <= slot_in;
      found_ff <= found_in;
      off_ff   <= off_in;
      kind_ff  <= kind_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      clamp_ff <= clamp_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
